// ===== design/jsu_pkg.sv =====
// Package for the JSON string unescaper: result and state types, phase and
// error codes, and the small decode helpers (hex digit, simple escape, UTF-8).
// Depends on nothing.
`default_nettype none

package jsu_pkg;

	localparam int unsigned MaxResults = 6;

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_STR     = 3'd1,
		PH_ESC     = 3'd2,
		PH_HEX     = 3'd3,
		PH_HIGH    = 3'd4,
		PH_HIGH_BS = 3'd5,
		PH_LOW_HEX = 3'd6
	} phase_t;

	localparam logic [1:0] KIND_BYTE  = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERR   = 2'd2;

	localparam logic [2:0] ERR_CTRL    = 3'd0;
	localparam logic [2:0] ERR_ESC     = 3'd1;
	localparam logic [2:0] ERR_HEX     = 3'd2;
	localparam logic [2:0] ERR_UNTERM  = 3'd3;
	localparam logic [2:0] ERR_NOQUOTE = 3'd4;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_U     = 8'h75;
	localparam logic [7:0] CTRL_LIM = 8'h20;

	localparam logic [15:0] HIGH_LO = 16'hD800;
	localparam logic [15:0] HIGH_HI = 16'hDBFF;
	localparam logic [15:0] LOW_LO  = 16'hDC00;
	localparam logic [15:0] LOW_HI  = 16'hDFFF;
	localparam logic [20:0] CP_REPL = 21'h00FFFD;
	localparam logic [20:0] CP_SUPP = 21'h010000;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [2:0] code;
	} result_t;

	typedef struct packed {
		phase_t      phase;
		logic [1:0]  digits;
		logic [11:0] accum;
		logic [9:0]  held;
	} state_t;

	localparam state_t ST_IDLE = '{phase: PH_IDLE, digits: 2'd0, accum: 12'd0, held: 10'd0};

	typedef struct packed {
		logic       ok;
		logic [7:0] value;
	} lookup_t;

	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      count;
	} utf8_t;

	typedef struct packed {
		logic       load;
		logic [2:0] count;
	} buf_load_t;

	function automatic lookup_t hex_value(input logic [7:0] b);
		lookup_t r;
		r.ok = 1'b1;
		r.value = 8'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r.value = b - 8'h30;
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r.value = b - 8'h57;
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r.value = b - 8'h37;
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

	function automatic lookup_t simple_escape(input logic [7:0] b);
		lookup_t r;
		r.ok = 1'b1;
		unique case (b)
			8'h22: r.value = 8'h22;
			8'h5C: r.value = 8'h5C;
			8'h2F: r.value = 8'h2F;
			8'h62: r.value = 8'h08;
			8'h66: r.value = 8'h0C;
			8'h6E: r.value = 8'h0A;
			8'h72: r.value = 8'h0D;
			8'h74: r.value = 8'h09;
			default: begin
				r.ok = 1'b0;
				r.value = 8'h00;
			end
		endcase
		return r;
	endfunction

	function automatic utf8_t utf8_encode(input logic [20:0] cp);
		utf8_t r;
		r.bytes = '0;
		if (cp < 21'h80) begin
			r.bytes[0] = cp[7:0];
			r.count = 3'd1;
		end else if (cp < 21'h800) begin
			r.bytes[0] = {3'b110, cp[10:6]};
			r.bytes[1] = {2'b10, cp[5:0]};
			r.count = 3'd2;
		end else if (cp < 21'h10000) begin
			r.bytes[0] = {4'b1110, cp[15:12]};
			r.bytes[1] = {2'b10, cp[11:6]};
			r.bytes[2] = {2'b10, cp[5:0]};
			r.count = 3'd3;
		end else begin
			r.bytes[0] = {5'b11110, cp[20:18]};
			r.bytes[1] = {2'b10, cp[17:12]};
			r.bytes[2] = {2'b10, cp[11:6]};
			r.bytes[3] = {2'b10, cp[5:0]};
			r.count = 3'd4;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== design/jsu_decode.sv =====
// Combinational decode of one text byte: next state and the list of result
// items it causes. Depends on jsu_pkg.
`default_nettype none

module jsu_decode (
	input  wire logic [7:0]                in_byte,
	input  wire logic                      end_of_text,
	input  wire jsu_pkg::state_t           cur,
	output jsu_pkg::state_t                nxt,
	output jsu_pkg::result_t [5:0]         res,
	output logic [2:0]                     res_count
);

	typedef struct packed {
		jsu_pkg::state_t             st;
		jsu_pkg::result_t [3:0]      r;
		logic [2:0]                  n;
	} step_t;

	function automatic jsu_pkg::result_t mk(input logic [1:0] kind, input logic [7:0] data,
			input logic [2:0] code);
		jsu_pkg::result_t r;
		r.kind = kind;
		r.data = data;
		r.code = code;
		return r;
	endfunction

	function automatic step_t fail(input logic [2:0] code);
		step_t o;
		o.st = jsu_pkg::ST_IDLE;
		o.r = '0;
		o.r[0] = mk(jsu_pkg::KIND_ERR, 8'd0, code);
		o.n = 3'd1;
		return o;
	endfunction

	function automatic step_t emit(input jsu_pkg::state_t s, input logic [20:0] cp);
		step_t o;
		jsu_pkg::utf8_t e;
		e = jsu_pkg::utf8_encode(cp);
		o.st = s;
		o.r = '0;
		for (int i = 0; i < 4; i++) begin
			o.r[i] = mk(jsu_pkg::KIND_BYTE, e.bytes[i], jsu_pkg::ERR_CTRL);
		end
		o.n = e.count;
		return o;
	endfunction

	function automatic step_t string_byte(input jsu_pkg::state_t s, input logic [7:0] b);
		step_t o;
		o.st = s;
		o.r = '0;
		o.n = 3'd0;
		if (b == jsu_pkg::CH_QUOTE) begin
			o.st = jsu_pkg::ST_IDLE;
			o.r[0] = mk(jsu_pkg::KIND_CLOSE, 8'd0, jsu_pkg::ERR_CTRL);
			o.n = 3'd1;
		end else if (b < jsu_pkg::CTRL_LIM) begin
			o = fail(jsu_pkg::ERR_CTRL);
		end else if (b == jsu_pkg::CH_BSL) begin
			o.st.phase = jsu_pkg::PH_ESC;
		end else begin
			o.r[0] = mk(jsu_pkg::KIND_BYTE, b, jsu_pkg::ERR_CTRL);
			o.n = 3'd1;
		end
		return o;
	endfunction

	function automatic step_t escape_char(input jsu_pkg::state_t s, input logic [7:0] b);
		step_t o;
		jsu_pkg::lookup_t m;
		m = jsu_pkg::simple_escape(b);
		o.st = s;
		o.r = '0;
		o.n = 3'd0;
		if (b == jsu_pkg::CH_U) begin
			o.st.phase = jsu_pkg::PH_HEX;
			o.st.digits = 2'd0;
			o.st.accum = 12'd0;
		end else if (m.ok) begin
			o.st.phase = jsu_pkg::PH_STR;
			o.r[0] = mk(jsu_pkg::KIND_BYTE, m.value, jsu_pkg::ERR_CTRL);
			o.n = 3'd1;
		end else begin
			o = fail(jsu_pkg::ERR_ESC);
		end
		return o;
	endfunction

	function automatic step_t fresh_unit(input jsu_pkg::state_t s, input logic [15:0] u);
		step_t o;
		jsu_pkg::state_t t;
		t = s;
		t.phase = jsu_pkg::PH_STR;
		if (u >= jsu_pkg::HIGH_LO && u <= jsu_pkg::HIGH_HI) begin
			o.st = s;
			o.st.held = u[9:0];
			o.st.phase = jsu_pkg::PH_HIGH;
			o.r = '0;
			o.n = 3'd0;
		end else if (u >= jsu_pkg::LOW_LO && u <= jsu_pkg::LOW_HI) begin
			o = emit(t, jsu_pkg::CP_REPL);
		end else begin
			o = emit(t, {5'd0, u});
		end
		return o;
	endfunction

	jsu_pkg::lookup_t hv;
	logic [15:0]      unit;
	logic             unit_done;
	logic             repl;
	step_t            st;
	jsu_pkg::state_t  s2;
	logic [2:0]       base;
	logic [2:0]       slot;

	assign hv = jsu_pkg::hex_value(in_byte);
	assign unit = {cur.accum, hv.value[3:0]};
	assign unit_done = (cur.digits == 2'd3);

	always_comb begin
		repl = 1'b0;
		s2 = cur;
		st.st = cur;
		st.r = '0;
		st.n = 3'd0;
		if (end_of_text) begin
			if (cur.phase != jsu_pkg::PH_IDLE && cur.phase <= jsu_pkg::PH_LOW_HEX) begin
				st = fail(jsu_pkg::ERR_UNTERM);
			end else begin
				st.st = jsu_pkg::ST_IDLE;
			end
		end else begin
			unique case (cur.phase)
				jsu_pkg::PH_STR: begin
					st = string_byte(cur, in_byte);
				end
				jsu_pkg::PH_ESC: begin
					st = escape_char(cur, in_byte);
				end
				jsu_pkg::PH_HEX: begin
					if (!hv.ok) begin
						st = fail(jsu_pkg::ERR_HEX);
					end else if (!unit_done) begin
						st.st.accum = unit[11:0];
						st.st.digits = cur.digits + 2'd1;
					end else begin
						s2.accum = 12'd0;
						s2.digits = 2'd0;
						st = fresh_unit(s2, unit);
					end
				end
				jsu_pkg::PH_HIGH: begin
					if (in_byte == jsu_pkg::CH_BSL) begin
						st.st.phase = jsu_pkg::PH_HIGH_BS;
					end else begin
						repl = 1'b1;
						s2.held = 10'd0;
						s2.phase = jsu_pkg::PH_STR;
						st = string_byte(s2, in_byte);
					end
				end
				jsu_pkg::PH_HIGH_BS: begin
					if (in_byte == jsu_pkg::CH_U) begin
						st.st.phase = jsu_pkg::PH_LOW_HEX;
						st.st.digits = 2'd0;
						st.st.accum = 12'd0;
					end else begin
						repl = 1'b1;
						s2.held = 10'd0;
						s2.phase = jsu_pkg::PH_STR;
						st = escape_char(s2, in_byte);
					end
				end
				jsu_pkg::PH_LOW_HEX: begin
					if (!hv.ok) begin
						repl = 1'b1;
						st = fail(jsu_pkg::ERR_HEX);
					end else if (!unit_done) begin
						st.st.accum = unit[11:0];
						st.st.digits = cur.digits + 2'd1;
					end else begin
						s2.accum = 12'd0;
						s2.digits = 2'd0;
						s2.held = 10'd0;
						if (unit >= jsu_pkg::LOW_LO && unit <= jsu_pkg::LOW_HI) begin
							s2.phase = jsu_pkg::PH_STR;
							st = emit(s2, jsu_pkg::CP_SUPP + {1'b0, cur.held, unit[9:0]});
						end else begin
							repl = 1'b1;
							st = fresh_unit(s2, unit);
						end
					end
				end
				default: begin
					// idle, and the unused phase code
					st.st = jsu_pkg::ST_IDLE;
					if (in_byte == jsu_pkg::CH_QUOTE) begin
						st.st.phase = jsu_pkg::PH_STR;
					end else begin
						st.r[0] = mk(jsu_pkg::KIND_ERR, 8'd0, jsu_pkg::ERR_NOQUOTE);
						st.n = 3'd1;
					end
				end
			endcase
		end
	end

	// Put the U+FFFD prefix first when the held surrogate was dropped.
	always_comb begin
		res = '0;
		slot = 3'd0;
		if (repl) begin
			res[0] = mk(jsu_pkg::KIND_BYTE, 8'hEF, jsu_pkg::ERR_CTRL);
			res[1] = mk(jsu_pkg::KIND_BYTE, 8'hBF, jsu_pkg::ERR_CTRL);
			res[2] = mk(jsu_pkg::KIND_BYTE, 8'hBD, jsu_pkg::ERR_CTRL);
			base = 3'd3;
		end else begin
			base = 3'd0;
		end
		for (int i = 0; i < 4; i++) begin
			slot = base + 3'(i);
			if (3'(i) < st.n && slot < 3'(jsu_pkg::MaxResults)) begin
				res[slot] = st.r[i];
			end
		end
		res_count = base + st.n;
		nxt = st.st;
	end

endmodule

`default_nettype wire

// ===== design/jsu_out_buf.sv =====
// Result register for the unescaper: holds the items of one input byte and
// hands them out one per cycle while out_stall is low. Depends on jsu_pkg.
`default_nettype none

module jsu_out_buf (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire jsu_pkg::buf_load_t    ld,
	input  wire jsu_pkg::result_t [5:0] res,
	output logic                       busy_hold,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [1:0]                 out_kind,
	output logic [7:0]                 out_byte,
	output logic [2:0]                 error_code,
	output logic                       last
);

	jsu_pkg::result_t [5:0] res_s1;
	logic [2:0]             cnt_q;
	logic [2:0]             idx_q;
	logic                   take;
	logic                   done;

	assign out_valid = (cnt_q != 3'd0);
	assign last = (idx_q == cnt_q - 3'd1);
	assign take = out_valid && !out_stall;
	assign done = take && last;
	// Hold the input while any item but a departing last one remains.
	assign busy_hold = out_valid && !done;

	assign out_kind = res_s1[idx_q].kind;
	assign out_byte = res_s1[idx_q].data;
	assign error_code = res_s1[idx_q].code;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 3'd0;
		end else if (ld.load) begin
			cnt_q <= ld.count;
			idx_q <= 3'd0;
		end else if (done) begin
			cnt_q <= 3'd0;
			idx_q <= 3'd0;
		end else if (take) begin
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load) begin
			res_s1 <= res;
		end
	end

endmodule

`default_nettype wire

// ===== design/json_string_unescape_utf8_core.sv =====
// Top level of the JSON string unescaper: state register, byte decode and
// result register. Depends on jsu_pkg, jsu_decode and jsu_out_buf.
`default_nettype none

// Channel   Direction  Handshake              Payload
// in        to block   in_valid / in_stall    in_byte, end_of_text
// out       from block out_valid / out_stall  out_kind, out_byte, error_code, last
//
// One text byte is taken per cycle while in_stall is low; its result items
// (zero to six) appear from the next cycle, one per cycle, from the result
// register. A byte that causes more than one item keeps the input stalled:
// the result register drains one item a cycle and takes the next byte as
// its last item leaves. A stall on the output holds the current item.
// Reset puts the decoder outside any string with nothing pending.

module json_string_unescape_utf8_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       end_of_text,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [1:0]      out_kind,
	output logic [7:0]      out_byte,
	output logic [2:0]      error_code,
	output logic            last
);

	jsu_pkg::state_t        state_q;
	jsu_pkg::state_t        state_nxt;
	jsu_pkg::result_t [5:0] res;
	logic [2:0]             res_count;
	logic                   accept;
	jsu_pkg::buf_load_t     ld;

	assign accept = in_valid && !in_stall;

	jsu_decode u_decode (
		.in_byte     (in_byte),
		.end_of_text (end_of_text),
		.cur         (state_q),
		.nxt         (state_nxt),
		.res         (res),
		.res_count   (res_count)
	);

	// Load the result register only for bytes that cause items.
	assign ld.load = accept && (res_count != 3'd0);
	assign ld.count = res_count;

	jsu_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.ld         (ld),
		.res        (res),
		.busy_hold  (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.error_code (error_code),
		.last       (last)
	);

	// Advance the escape state on every accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= jsu_pkg::ST_IDLE;
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

endmodule

`default_nettype wire

// ===== verif/jsu_unescape_checker.sv =====
// Result checker for the JSON string unescaper. It follows both channels,
// predicts the result items of each accepted text byte and compares them in order.
// Depends on jsu_pkg for the phase, kind and error codes.

module jsu_unescape_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       end_of_text,
	input  logic       out_valid,
	input  logic       out_stall,
	input  logic [1:0] out_kind,
	input  logic [7:0] out_byte,
	input  logic [2:0] error_code,
	input  logic       last,
	output int         fail_count,
	output int         pending
);

	localparam logic [2:0] NO_CODE = 3'd0;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [2:0] code;
		logic       last;
	} decoded_t;

	// Decoder state as the text has been seen so far
	jsu_pkg::phase_t ph;
	logic [1:0]      ndig;
	logic [15:0]     accum;
	logic [15:0]     held;

	decoded_t step_q[$];
	decoded_t outstanding_q[$];

	function automatic void emit(input logic [1:0] kind, input logic [7:0] data,
			input logic [2:0] code);
		decoded_t d;
		d.kind = kind;
		d.data = data;
		d.code = code;
		d.last = 1'b0;
		step_q = {step_q, d};
	endfunction

	function automatic void emit_utf8(input logic [20:0] cp);
		if (cp < 21'h80) begin
			emit(jsu_pkg::KIND_BYTE, cp[7:0], NO_CODE);
		end else if (cp < 21'h800) begin
			emit(jsu_pkg::KIND_BYTE, {3'b110, cp[10:6]}, NO_CODE);
			emit(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, NO_CODE);
		end else if (cp < jsu_pkg::CP_SUPP) begin
			emit(jsu_pkg::KIND_BYTE, {4'b1110, cp[15:12]}, NO_CODE);
			emit(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]}, NO_CODE);
			emit(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, NO_CODE);
		end else begin
			emit(jsu_pkg::KIND_BYTE, {5'b11110, cp[20:18]}, NO_CODE);
			emit(jsu_pkg::KIND_BYTE, {2'b10, cp[17:12]}, NO_CODE);
			emit(jsu_pkg::KIND_BYTE, {2'b10, cp[11:6]}, NO_CODE);
			emit(jsu_pkg::KIND_BYTE, {2'b10, cp[5:0]}, NO_CODE);
		end
	endfunction

	function automatic void to_idle();
		ph = jsu_pkg::PH_IDLE;
		ndig = 2'd0;
		accum = 16'd0;
		held = 16'd0;
	endfunction

	// Any error drops the open string
	function automatic void raise(input logic [2:0] code);
		emit(jsu_pkg::KIND_ERR, 8'h00, code);
		to_idle();
	endfunction

	function automatic int hex_nibble(input logic [7:0] b);
		if (b >= "0" && b <= "9") return b - "0";
		if (b >= "a" && b <= "f") return b - "a" + 10;
		if (b >= "A" && b <= "F") return b - "A" + 10;
		return -1;
	endfunction

	function automatic void plain_byte(input logic [7:0] b);
		if (b == jsu_pkg::CH_QUOTE) begin
			emit(jsu_pkg::KIND_CLOSE, 8'h00, NO_CODE);
			to_idle();
		end else if (b < jsu_pkg::CTRL_LIM) begin
			raise(jsu_pkg::ERR_CTRL);
		end else if (b == jsu_pkg::CH_BSL) begin
			ph = jsu_pkg::PH_ESC;
		end else begin
			emit(jsu_pkg::KIND_BYTE, b, NO_CODE);
		end
	endfunction

	function automatic void escape_byte(input logic [7:0] b);
		logic [7:0] v;
		v = 8'h00;
		case (b)
			jsu_pkg::CH_QUOTE: v = jsu_pkg::CH_QUOTE;
			jsu_pkg::CH_BSL:   v = jsu_pkg::CH_BSL;
			"/":               v = "/";
			"b":               v = 8'h08;
			"f":               v = 8'h0C;
			"n":               v = 8'h0A;
			"r":               v = 8'h0D;
			"t":               v = 8'h09;
			jsu_pkg::CH_U: begin
				ph = jsu_pkg::PH_HEX;
				ndig = 2'd0;
				accum = 16'd0;
				return;
			end
			default: begin
				raise(jsu_pkg::ERR_ESC);
				return;
			end
		endcase
		emit(jsu_pkg::KIND_BYTE, v, NO_CODE);
		ph = jsu_pkg::PH_STR;
	endfunction

	// A complete \u unit: a high surrogate waits for its partner
	function automatic void unit_done(input logic [15:0] u);
		if (u >= jsu_pkg::HIGH_LO && u <= jsu_pkg::HIGH_HI) begin
			held = u;
			ph = jsu_pkg::PH_HIGH;
			return;
		end
		if (u >= jsu_pkg::LOW_LO && u <= jsu_pkg::LOW_HI) emit_utf8(jsu_pkg::CP_REPL);
		else emit_utf8({5'd0, u});
		ph = jsu_pkg::PH_STR;
	endfunction

	function automatic logic shift_digit(input logic [3:0] v, output logic [15:0] u);
		accum = {accum[11:0], v};
		u = accum;
		if (ndig == 2'd3) begin
			ndig = 2'd0;
			accum = 16'd0;
			return 1'b1;
		end
		ndig = ndig + 2'd1;
		return 1'b0;
	endfunction

	function automatic void predict(input logic [7:0] b, input logic eot);
		int v;
		logic [15:0] u;
		logic [15:0] hoff;
		logic [20:0] cp;
		decoded_t d;
		step_q.delete();
		if (eot) begin
			if (ph != jsu_pkg::PH_IDLE) raise(jsu_pkg::ERR_UNTERM);
			else to_idle();
		end else begin
			case (ph)
				jsu_pkg::PH_STR: plain_byte(b);
				jsu_pkg::PH_ESC: escape_byte(b);
				jsu_pkg::PH_HEX: begin
					v = hex_nibble(b);
					if (v < 0) raise(jsu_pkg::ERR_HEX);
					else if (shift_digit(v[3:0], u)) unit_done(u);
				end
				jsu_pkg::PH_HIGH: begin
					if (b == jsu_pkg::CH_BSL) begin
						ph = jsu_pkg::PH_HIGH_BS;
					end else begin
						emit_utf8(jsu_pkg::CP_REPL);
						held = 16'd0;
						ph = jsu_pkg::PH_STR;
						plain_byte(b);
					end
				end
				jsu_pkg::PH_HIGH_BS: begin
					if (b == jsu_pkg::CH_U) begin
						ph = jsu_pkg::PH_LOW_HEX;
						ndig = 2'd0;
						accum = 16'd0;
					end else begin
						emit_utf8(jsu_pkg::CP_REPL);
						held = 16'd0;
						ph = jsu_pkg::PH_STR;
						escape_byte(b);
					end
				end
				jsu_pkg::PH_LOW_HEX: begin
					v = hex_nibble(b);
					if (v < 0) begin
						emit_utf8(jsu_pkg::CP_REPL);
						raise(jsu_pkg::ERR_HEX);
					end else if (shift_digit(v[3:0], u)) begin
						if (u >= jsu_pkg::LOW_LO && u <= jsu_pkg::LOW_HI) begin
							hoff = held - jsu_pkg::HIGH_LO;
							cp = jsu_pkg::CP_SUPP + {hoff[9:0], 10'd0}
								+ 21'(u - jsu_pkg::LOW_LO);
							held = 16'd0;
							emit_utf8(cp);
							ph = jsu_pkg::PH_STR;
						end else begin
							emit_utf8(jsu_pkg::CP_REPL);
							held = 16'd0;
							unit_done(u);
						end
					end
				end
				default: begin
					to_idle();
					if (b == jsu_pkg::CH_QUOTE) ph = jsu_pkg::PH_STR;
					else emit(jsu_pkg::KIND_ERR, 8'h00, jsu_pkg::ERR_NOQUOTE);
				end
			endcase
		end
		if (step_q.size() > 0) begin
			d = step_q.pop_back();
			d.last = 1'b1;
			step_q = {step_q, d};
		end
		outstanding_q = {outstanding_q, step_q};
	endfunction

	function automatic void check_field(input string what, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
			fail_count++;
		end
	endfunction

	initial begin
		fail_count = 0;
		pending = 0;
		to_idle();
	end

	always @(posedge clk or negedge arst_n) begin : watch
		decoded_t want;
		if (!arst_n) begin
			to_idle();
			outstanding_q.delete();
		end else begin
			if (out_valid && !out_stall) begin
				if (outstanding_q.size() == 0) begin
					$display({"%0t: unexpected result, expected none, ",
						"actual kind %0d byte %0d code %0d last %0d"},
						$time, out_kind, out_byte, error_code, last);
					fail_count++;
				end else begin
					want = outstanding_q.pop_front();
					check_field("out_kind", 8'(want.kind), 8'(out_kind));
					check_field("out_byte", want.data, out_byte);
					check_field("error_code", 8'(want.code), 8'(error_code));
					check_field("last", 8'(want.last), 8'(last));
				end
			end
			if (in_valid && !in_stall) predict(in_byte, end_of_text);
		end
		pending = outstanding_q.size();
	end

endmodule

// ===== verif/tb_json_string_unescape_utf8_core.sv =====
// Testbench top for the JSON string unescaper: clock, reset, text stimulus and
// a randomly stalling result sink. Depends on jsu_pkg, the block and
// jsu_unescape_checker, which predicts and compares every result item.

module tb_json_string_unescape_utf8_core;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] in_byte;
	logic       end_of_text;
	logic       out_valid;
	logic       out_stall;
	logic [1:0] out_kind;
	logic [7:0] out_byte;
	logic [2:0] error_code;
	logic       last;

	int fail_count;
	int pending;

	// Text bytes sent so far; end-of-text markers are not counted
	int   text_bytes;
	// Sender runs without gaps while set
	logic rush;

	// The eight simple escape letters that follow a backslash
	logic [7:0] esc_chars [8] = '{jsu_pkg::CH_QUOTE, jsu_pkg::CH_BSL, "/", "b", "f", "n", "r",
		"t"};

	json_string_unescape_utf8_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.error_code (error_code),
		.last       (last)
	);

	jsu_unescape_checker result_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.end_of_text(end_of_text),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_kind   (out_kind),
		.out_byte   (out_byte),
		.error_code (error_code),
		.last       (last),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

	// Offer one item: idle a random number of cycles, then hold the item
	// until the block takes it. Valid stays high after acceptance so that
	// back-to-back items never drop it within one time step.
	task automatic send_item(input logic [7:0] b, input logic eot);
		int gap;
		gap = rush ? 0 : $urandom_range(0, 12);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= b;
		end_of_text <= eot;
		do @(posedge clk); while (in_stall);
		if (!eot) text_bytes++;
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	// Drop valid and hold the sender until every predicted item is back; the
	// closing wait covers a byte that gives no result at all.
	task automatic drain_input();
		@(negedge clk);
		in_valid <= 1'b0;
		wait (pending == 0);
		repeat (2) @(posedge clk);
	endtask

	// Hex digit with random letter case
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		if (n < 4'd10) return 8'h30 + n;
		return (($urandom_range(0, 1) != 0) ? 8'h61 : 8'h41) + n - 8'd10;
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		return (b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F");
	endfunction

	function automatic logic is_escape(input logic [7:0] b);
		int i;
		if (b == jsu_pkg::CH_U) return 1'b1;
		for (i = 0; i < 8; i++) if (esc_chars[i] == b) return 1'b1;
		return 1'b0;
	endfunction

	// Code unit from one of the encoding classes, surrogates included
	function automatic logic [15:0] pick_unit();
		case ($urandom_range(0, 6))
			0: return 16'($urandom_range(0, 16'h7F));
			1: return 16'($urandom_range(16'h80, 16'h7FF));
			2: return 16'($urandom_range(16'h800, 16'hD7FF));
			3: return 16'($urandom_range(16'hE000, 16'hFFFF));
			4: return 16'($urandom_range(jsu_pkg::HIGH_LO, jsu_pkg::HIGH_HI));
			5: return 16'($urandom_range(jsu_pkg::LOW_LO, jsu_pkg::LOW_HI));
			default: return ($urandom_range(0, 1) != 0) ? 16'h0000 : 16'hFFFF;
		endcase
	endfunction

	task automatic send_unit(input logic [15:0] u);
		int i;
		send_item(jsu_pkg::CH_BSL, 1'b0);
		send_item(jsu_pkg::CH_U, 1'b0);
		for (i = 3; i >= 0; i--) send_item(hex_char(u[4*i +: 4]), 1'b0);
	endtask

	// One piece of string content. A bare high surrogate is left for the
	// next piece or the ending to resolve: pair, plain byte, escape or error.
	task automatic send_piece();
		logic [7:0] b;
		case ($urandom_range(0, 8))
			0, 1: begin
				b = 8'($urandom_range(8'h20, 8'h7E));
				if (b == jsu_pkg::CH_QUOTE || b == jsu_pkg::CH_BSL) b = "a";
				send_item(b, 1'b0);
			end
			2: send_item(8'($urandom_range(8'h80, 8'hFF)), 1'b0);
			3: begin
				send_item(jsu_pkg::CH_BSL, 1'b0);
				send_item(esc_chars[$urandom_range(0, 7)], 1'b0);
			end
			4: send_unit(pick_unit());
			5, 6: begin
				send_unit(16'($urandom_range(jsu_pkg::HIGH_LO, jsu_pkg::HIGH_HI)));
				send_unit(16'($urandom_range(jsu_pkg::LOW_LO, jsu_pkg::LOW_HI)));
			end
			default: send_unit(16'($urandom_range(jsu_pkg::HIGH_LO, jsu_pkg::HIGH_HI)));
		endcase
	endtask

	// Close the string, mostly cleanly, sometimes with each kind of in-string error
	task automatic send_ending();
		logic [7:0] b;
		int sel;
		sel = $urandom_range(0, 19);
		case (sel)
			14: send_item(8'($urandom), 1'b1);
			15: send_item(8'($urandom_range(0, 8'h1F)), 1'b0);
			16: begin
				do b = 8'($urandom); while (is_escape(b));
				send_item(jsu_pkg::CH_BSL, 1'b0);
				send_item(b, 1'b0);
			end
			17, 18: begin
				// bad hex digit, in a first unit or after a held high surrogate
				if (sel == 18) send_unit(16'($urandom_range(jsu_pkg::HIGH_LO, jsu_pkg::HIGH_HI)));
				send_item(jsu_pkg::CH_BSL, 1'b0);
				send_item(jsu_pkg::CH_U, 1'b0);
				repeat ($urandom_range(0, 3)) send_item(hex_char(4'($urandom)), 1'b0);
				do b = 8'($urandom); while (is_hex(b));
				send_item(b, 1'b0);
			end
			19: begin
				// text ends in the middle of an escape
				send_item(jsu_pkg::CH_BSL, 1'b0);
				if ($urandom_range(0, 1) != 0) begin
					send_item(jsu_pkg::CH_U, 1'b0);
					repeat ($urandom_range(0, 3)) send_item(hex_char(4'($urandom)), 1'b0);
				end
				send_item(8'($urandom), 1'b1);
			end
			default: send_item(jsu_pkg::CH_QUOTE, 1'b0);
		endcase
	endtask

	// Result sink: a random stall before every item, a long hold twice so
	// that the block backs up into its input, and a window with no stalls.
	initial begin : receiver
		int hold;
		int taken;
		taken = 0;
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if (taken == 30 || taken == 170) hold = 100;
			else if (taken >= 100 && taken < 140) hold = 0;
			else hold = $urandom_range(0, 12);
			@(negedge clk);
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
			taken++;
		end
	end

	initial begin : stimulus
		logic paused;
		in_valid = 1'b0;
		in_byte = 8'h00;
		end_of_text = 1'b0;
		rush = 1'b0;
		text_bytes = 0;
		paused = 1'b0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: byte outside a string, end of text while idle
		send_item("A", 1'b0);
		send_item(8'h5A, 1'b1);
		// Lowest printable, highest printable ASCII, raw bytes at both ends, an escape, close
		send_item(jsu_pkg::CH_QUOTE, 1'b0);
		send_item(8'h20, 1'b0);
		send_item(8'h7E, 1'b0);
		send_item(8'hFF, 1'b0);
		send_item(8'h80, 1'b0);
		send_text("\\/\"");
		// Highest surrogate pair (four output bytes), then a control byte
		send_text("\"\\uDBFF\\udfff");
		send_item(8'h1F, 1'b0);
		// Lone low surrogate, then end of text inside the string
		send_text("\"\\uDC00x");
		send_item(8'h00, 1'b1);
		// Bad escape letter
		send_text("\"\\q");

		// Hold the sender until all directed results are back
		drain_input();
		text_bytes = 0;

		// Random: mostly well-formed strings with random content, some noise
		while (text_bytes < 140) begin
			if (!paused && text_bytes >= 70) begin
				drain_input();
				paused = 1'b1;
			end
			rush = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 9) < 7) begin
				send_item(jsu_pkg::CH_QUOTE, 1'b0);
				repeat ($urandom_range(0, 6)) send_piece();
				send_ending();
			end else begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(0, 7) == 0) send_item(8'($urandom), 1'b1);
					else send_item(8'($urandom), 1'b0);
				end
			end
		end

		// Let every expected item arrive, then watch a little longer for strays
		drain_input();
		repeat (16) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
design/jsu_pkg.sv
design/jsu_decode.sv
design/jsu_out_buf.sv
design/json_string_unescape_utf8_core.sv
verif/jsu_unescape_checker.sv
verif/tb_json_string_unescape_utf8_core.sv
